// ===== sv/qbf_pkg.sv =====
// Shared types, constants and control structs of the quadratic Bezier flattener.
package qbf_pkg;

	localparam int MAX_DEPTH_DEF   = 6;
	localparam int COORD_WIDTH_DEF = 32;
	localparam int TOL_W           = 31;
	localparam logic [TOL_W-1:0] TOL_RESET = 31'd65536;

	typedef struct packed {
		logic signed [31:0] start_x;
		logic signed [31:0] start_y;
		logic signed [31:0] ctrl_x;
		logic signed [31:0] ctrl_y;
		logic signed [31:0] end_x;
		logic signed [31:0] end_y;
	} qbf_req_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic               last_point;
	} qbf_res_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic eval;
		logic split;
		logic emit;
	} qbf_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic flat;
		logic at_max;
		logic stack_empty;
	} qbf_stat_t;

endpackage

// ===== sv/quad_bezier_flattener.sv =====
// Top level of the quadratic Bezier flattener.
//
//  channel   | ports                       | handshake
//  ----------+-----------------------------+-----------------------------------
//  request   | start, busy, request        | taken when start=1 and busy=0
//  result    | result_valid, result        | one-cycle strobe, cannot be held off
//  config    | cfg_we, cfg_wdata           | flatness tolerance, written on cfg_we
//
// Each subdivision step registers the deviation magnitudes in ST_EVAL, then
// does the tolerance compare and the split or emit in ST_DECIDE.
// A curve gives at most 64 points; busy falls as the final point is strobed.
// Reset sets the tolerance to 65536 and empties the stack; no clearing pass.
// Results leave on a strobe the receiver must take; nothing stalls inside.
module quad_bezier_flattener #(
	parameter int MAX_DEPTH   = qbf_pkg::MAX_DEPTH_DEF,
	parameter int COORD_WIDTH = qbf_pkg::COORD_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  qbf_pkg::qbf_req_t         request,
	input  logic                      cfg_we,
	input  logic [qbf_pkg::TOL_W-1:0] cfg_wdata,
	output logic                      result_valid,
	output qbf_pkg::qbf_res_t         result
);

	qbf_pkg::qbf_cmd_t  cmd;
	qbf_pkg::qbf_stat_t stat;

	qbf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	qbf_datapath #(
		.MAX_DEPTH   (MAX_DEPTH),
		.COORD_WIDTH (COORD_WIDTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.request      (request),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.stat         (stat),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

// ===== sv/qbf_ctrl.sv =====
// Controller state machine of the quadratic Bezier flattener.
module qbf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  qbf_pkg::qbf_stat_t  stat,
	output qbf_pkg::qbf_cmd_t   cmd,
	output logic                busy
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DECIDE
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   do_emit;

	assign do_emit = stat.flat || stat.at_max;
	assign busy    = busy_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load = start;
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
			end
			ST_DECIDE: begin
				cmd.emit  = do_emit;
				cmd.split = !do_emit;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_EVAL;
						busy_q  <= 1'b1;
					end
				end
				ST_EVAL: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					// The final point leaves with an empty stack; the curve is done.
					if (do_emit && stat.stack_empty) begin
						state_q <= ST_IDLE;
						busy_q  <= 1'b0;
					end else begin
						state_q <= ST_EVAL;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

endmodule

// ===== sv/qbf_datapath.sv =====
// Datapath of the quadratic Bezier flattener: segment registers, stack, flatness test.
module qbf_datapath #(
	parameter int MAX_DEPTH   = qbf_pkg::MAX_DEPTH_DEF,
	parameter int COORD_WIDTH = qbf_pkg::COORD_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  qbf_pkg::qbf_cmd_t           cmd,
	input  qbf_pkg::qbf_req_t           request,
	input  logic                        cfg_we,
	input  logic [qbf_pkg::TOL_W-1:0]   cfg_wdata,
	output qbf_pkg::qbf_stat_t          stat,
	output logic                        result_valid,
	output qbf_pkg::qbf_res_t           result
);

	localparam int CW       = COORD_WIDTH;
	localparam int LVL_W    = $clog2(MAX_DEPTH + 1);
	localparam int SP_IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int ENT_W    = 4 * CW + LVL_W;
	localparam int CMP_W    = (CW + 2 > qbf_pkg::TOL_W) ? CW + 2 : qbf_pkg::TOL_W;

	typedef logic signed [CW-1:0] coord_t;

	// Floor of (a + b) / 2, taken one bit wider so the sum cannot overflow.
	function automatic coord_t half_sum(input coord_t a, input coord_t b);
		logic signed [CW:0] s;
		s = (CW+1)'(a) + (CW+1)'(b);
		return coord_t'(s[CW:1]);
	endfunction

	function automatic logic [CW:0] dev_mag(input coord_t c, input coord_t h);
		logic signed [CW:0] d;
		d = (CW+1)'(c) - (CW+1)'(h);
		return d[CW] ? (CW+1)'(-d) : (CW+1)'(d);
	endfunction

	coord_t sx_q, sy_q, cx_q, cy_q, ex_q, ey_q;
	logic [LVL_W-1:0]        lvl_q;
	logic [LVL_W-1:0]        sp_q;
	logic [LVL_W-1:0]        sp_dec;
	logic [CW:0]             magx_q, magy_q;
	logic [qbf_pkg::TOL_W-1:0] tol_q;
	logic [ENT_W-1:0]        stk_q [MAX_DEPTH];
	logic [ENT_W-1:0]        stk_rd;
	logic [CMP_W-1:0]        dev;
	coord_t lx, ly, rx, ry, mx, my;
	coord_t pop_cx, pop_cy, pop_ex, pop_ey;
	logic [LVL_W-1:0]        pop_lvl;
	qbf_pkg::qbf_res_t       res_q;
	logic                    res_valid_q;

	assign lx = half_sum(sx_q, cx_q);
	assign ly = half_sum(sy_q, cy_q);
	assign rx = half_sum(cx_q, ex_q);
	assign ry = half_sum(cy_q, ey_q);
	assign mx = half_sum(lx, rx);
	assign my = half_sum(ly, ry);

	assign dev = CMP_W'(magx_q) + CMP_W'(magy_q);

	assign sp_dec = sp_q - LVL_W'(1);
	assign stk_rd = stk_q[sp_dec[SP_IDX_W-1:0]];
	assign {pop_cx, pop_cy, pop_ex, pop_ey, pop_lvl} = stk_rd;

	assign stat.flat        = dev <= CMP_W'(tol_q);
	assign stat.at_max      = lvl_q == LVL_W'(MAX_DEPTH);
	assign stat.stack_empty = sp_q == '0;

	assign result_valid = res_valid_q;
	assign result       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q       <= qbf_pkg::TOL_RESET;
			sp_q        <= '0;
			lvl_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= cmd.emit;
			if (cfg_we) begin
				tol_q <= cfg_wdata;
			end
			if (cmd.load) begin
				sp_q  <= '0;
				lvl_q <= '0;
			end else if (cmd.split) begin
				sp_q  <= sp_q + LVL_W'(1);
				lvl_q <= lvl_q + LVL_W'(1);
			end else if (cmd.emit && sp_q != '0) begin
				sp_q  <= sp_dec;
				lvl_q <= pop_lvl;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sx_q <= coord_t'(request.start_x[CW-1:0]);
			sy_q <= coord_t'(request.start_y[CW-1:0]);
			cx_q <= coord_t'(request.ctrl_x[CW-1:0]);
			cy_q <= coord_t'(request.ctrl_y[CW-1:0]);
			ex_q <= coord_t'(request.end_x[CW-1:0]);
			ey_q <= coord_t'(request.end_y[CW-1:0]);
		end else if (cmd.split) begin
			// Keep the left half, park the right half on the stack.
			stk_q[sp_q[SP_IDX_W-1:0]] <= {rx, ry, ex_q, ey_q, lvl_q + LVL_W'(1)};
			cx_q <= lx;
			cy_q <= ly;
			ex_q <= mx;
			ey_q <= my;
		end else if (cmd.emit && sp_q != '0) begin
			sx_q <= ex_q;
			sy_q <= ey_q;
			cx_q <= pop_cx;
			cy_q <= pop_cy;
			ex_q <= pop_ex;
			ey_q <= pop_ey;
		end
		if (cmd.eval) begin
			magx_q <= dev_mag(cx_q, half_sum(sx_q, ex_q));
			magy_q <= dev_mag(cy_q, half_sum(sy_q, ey_q));
		end
		if (cmd.emit) begin
			res_q.out_x      <= 32'(ex_q);
			res_q.out_y      <= 32'(ey_q);
			res_q.last_point <= sp_q == '0;
		end
	end

	a_sp_le_lvl: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= lvl_q)
		else $error("stack depth exceeds subdivision level");

	a_lvl_range: assert property (@(posedge clk) disable iff (!arst_n)
		lvl_q <= LVL_W'(MAX_DEPTH))
		else $error("subdivision level beyond depth limit");

	a_split_below_max: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.split |-> (lvl_q < LVL_W'(MAX_DEPTH)) && !stat.flat)
		else $error("split issued on a segment that must be emitted");

	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.last_point |=> !res_valid_q)
		else $error("result follows the final point of a curve too closely");

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench of the quadratic Bezier flattener.
`timescale 1ns / 1ps

module testbench;

	localparam int IDLE_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 260;
	localparam logic [qbf_pkg::TOL_W-1:0] TOL_MAX = '1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	qbf_pkg::qbf_req_t request = '0;
	logic cfg_we = 1'b0;
	logic [qbf_pkg::TOL_W-1:0] cfg_wdata = '0;
	logic result_valid;
	qbf_pkg::qbf_res_t result;

	qbf_pkg::qbf_res_t expected_points[$];
	longint flat_tol = 65536;
	int fail_count = 0;
	int quiet_cycles = 0;
	bit idle_on = 1'b1;

	quad_bezier_flattener i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.result_valid(result_valid),
		.result(result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint mid(longint a, longint b);
		return (a + b) >>> 1;
	endfunction

	function automatic longint magnitude(longint v);
		return (v < 0) ? -v : v;
	endfunction

	// Depth-first subdivision, left half first; right halves wait on a small stack.
	function automatic void flatten_curve(qbf_pkg::qbf_req_t c);
		longint sx, sy, cx, cy, ex, ey;
		longint lx, ly, rx, ry, mx, my, dev;
		longint held_cx[6], held_cy[6], held_ex[6], held_ey[6];
		int held_lvl[6];
		int lvl, top;
		qbf_pkg::qbf_res_t pt;
		sx = $signed(c.start_x);
		sy = $signed(c.start_y);
		cx = $signed(c.ctrl_x);
		cy = $signed(c.ctrl_y);
		ex = $signed(c.end_x);
		ey = $signed(c.end_y);
		lvl = 0;
		top = 0;
		while (1'b1) begin
			dev = magnitude(cx - mid(sx, ex)) + magnitude(cy - mid(sy, ey));
			if (dev <= flat_tol || lvl >= qbf_pkg::MAX_DEPTH_DEF || top >= 6) begin
				pt.out_x = ex[31:0];
				pt.out_y = ey[31:0];
				pt.last_point = (top == 0);
				expected_points.push_back(pt);
				if (top == 0)
					break;
				sx = ex;
				sy = ey;
				top--;
				cx = held_cx[top];
				cy = held_cy[top];
				ex = held_ex[top];
				ey = held_ey[top];
				lvl = held_lvl[top];
			end else begin
				lx = mid(sx, cx);
				ly = mid(sy, cy);
				rx = mid(cx, ex);
				ry = mid(cy, ey);
				mx = mid(lx, rx);
				my = mid(ly, ry);
				held_cx[top] = rx;
				held_cy[top] = ry;
				held_ex[top] = ex;
				held_ey[top] = ey;
				held_lvl[top] = lvl + 1;
				top++;
				cx = lx;
				cy = ly;
				ex = mx;
				ey = my;
				lvl++;
			end
		end
	endfunction

	function automatic void note_failure(string what);
		fail_count++;
		if (fail_count <= 10)
			$display("%s", what);
	endfunction

	always @(posedge clk) begin : check_points
		qbf_pkg::qbf_res_t want;
		if (arst_n && result_valid) begin
			if (expected_points.size() == 0) begin
				note_failure($sformatf("unexpected point x=%h y=%h last=%b",
					result.out_x, result.out_y, result.last_point));
			end else begin
				want = expected_points.pop_front();
				if (result.out_x !== want.out_x || result.out_y !== want.out_y ||
						result.last_point !== want.last_point)
					note_failure($sformatf(
						"point mismatch: expected x=%h y=%h last=%b, got x=%h y=%h last=%b",
						want.out_x, want.out_y, want.last_point,
						result.out_x, result.out_y, result.last_point));
			end
		end
	end

	// Ends the run when neither a request nor a point moves for too long.
	always @(posedge clk) begin
		if ((start && !busy) || result_valid)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Presents one curve and holds it until taken; start may drop for a short burst.
	task automatic send_curve(qbf_pkg::qbf_req_t c);
		if (idle_on && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) @(posedge clk);
		@(posedge clk);
		start <= 1'b1;
		request <= c;
		while (1'b1) begin
			@(posedge clk);
			if (start && !busy)
				break;
			if (idle_on && $urandom_range(0, 15) == 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
				start <= 1'b1;
			end
		end
		start <= 1'b0;
		flatten_curve(c);
	endtask

	task automatic wait_drained();
		while (expected_points.size() != 0 || busy)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_tolerance(logic [qbf_pkg::TOL_W-1:0] v);
		wait_drained();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		flat_tol = v;
	endtask

	function automatic qbf_pkg::qbf_req_t curve(int sx, int sy, int cx, int cy, int ex,
			int ey);
		qbf_pkg::qbf_req_t c;
		c.start_x = sx;
		c.start_y = sy;
		c.ctrl_x = cx;
		c.ctrl_y = cy;
		c.end_x = ex;
		c.end_y = ey;
		return c;
	endfunction

	function automatic logic [31:0] scaled_offset(int scale);
		logic signed [31:0] r;
		r = $urandom;
		return r >>> (32 - scale);
	endfunction

	// Points cluster around a base with a spread of 2^scale, so deviations vary widely.
	function automatic qbf_pkg::qbf_req_t random_curve();
		qbf_pkg::qbf_req_t c;
		logic [31:0] bx, by;
		int scale;
		scale = $urandom_range(1, 32);
		bx = ($urandom_range(0, 1) == 1) ? $urandom : 32'd0;
		by = ($urandom_range(0, 1) == 1) ? $urandom : 32'd0;
		c.start_x = bx + scaled_offset(scale);
		c.start_y = by + scaled_offset(scale);
		c.ctrl_x = bx + scaled_offset(scale);
		c.ctrl_y = by + scaled_offset(scale);
		c.end_x = bx + scaled_offset(scale);
		c.end_y = by + scaled_offset(scale);
		return c;
	endfunction

	function automatic logic [qbf_pkg::TOL_W-1:0] random_tolerance();
		unique case ($urandom_range(0, 4))
			0: return '0;
			1: return TOL_MAX;
			2: return qbf_pkg::TOL_RESET;
			3: return qbf_pkg::TOL_W'($urandom_range(0, 1 << 20));
			default: return qbf_pkg::TOL_W'($urandom >> $urandom_range(1, 31));
		endcase
	endfunction

	task automatic test_special_curves();
		int mn, mx;
		mn = 32'h8000_0000;
		mx = 32'h7FFF_FFFF;
		// Degenerate curves collapse to a single point.
		send_curve(curve(0, 0, 0, 0, 0, 0));
		send_curve(curve(mx, mx, mx, mx, mx, mx));
		send_curve(curve(mn, mn, mn, mn, mn, mn));
		send_curve(curve(32'h1234_5678, -5, 32'h1234_5678, -5, 32'h1234_5678, -5));
		// A straight line is flat at once.
		send_curve(curve(0, 0, 1 << 20, 1 << 20, 2 << 20, 2 << 20));
		// One split is enough here.
		send_curve(curve(0, 0, 32'h40000, 32'h40000, 32'h80000, 0));
		// Huge deviations run into the depth limit; the last curve here is small and flat at once.
		send_curve(curve(mn, mn, mx, mx, mn, mn));
		send_curve(curve(mx, mn, mn, mx, mx, mn));
		send_curve(curve(0, 0, mx, mn, 0, 0));
		send_curve(curve(mn, mx, mx, mn, mx, mx));
		send_curve(curve(-1, -3, 5, -7, -2, 4));
	endtask

	task automatic test_tolerance_extremes();
		int mn, mx;
		mn = 32'h8000_0000;
		mx = 32'h7FFF_FFFF;
		set_tolerance('0);
		send_curve(curve(-1, -3, 5, -7, -2, 4));
		send_curve(curve(0, 0, 1, 0, 2, 0));
		send_curve(curve(0, 0, 2, 0, 4, 0));
		send_curve(curve(3, -3, -3, 3, 3, -3));
		set_tolerance(TOL_MAX);
		send_curve(curve(0, 0, mx, 0, 0, 0));
		send_curve(curve(0, 0, mx, mx, 0, 0));
		send_curve(curve(mn, mn, mx, mx, mn, mn));
		send_curve(curve(mx, mn, mn, mx, mx, mn));
		set_tolerance(qbf_pkg::TOL_W'(1));
		send_curve(curve(0, 0, 3, 0, 0, 0));
		send_curve(curve(-7, 9, 11, -13, 2, 6));
		set_tolerance(qbf_pkg::TOL_RESET);
		send_curve(curve(32'h10000, 32'h10000, 32'h30000, 32'h20000, 32'h50000, 32'h10000));
	endtask

	task automatic test_random_curves();
		for (int batch = 0; batch < 11; batch++) begin
			if ($urandom_range(0, 1) == 1)
				set_tolerance(random_tolerance());
			for (int i = 0; i < 25; i++)
				send_curve(random_curve());
		end
	endtask

	task automatic test_back_to_back();
		idle_on = 1'b0;
		set_tolerance(qbf_pkg::TOL_W'($urandom_range(1 << 12, 1 << 18)));
		for (int i = 0; i < 50; i++)
			send_curve(random_curve());
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_special_curves();
		test_tolerance_extremes();
		test_random_curves();
		test_back_to_back();
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_points.size() != 0)
			note_failure($sformatf("%0d points never arrived", expected_points.size()));
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
